// ----- hw/rtl/sha256_stream_hasher_unit_defines.svh -----
// Assertion macros for the SHA-256 stream hasher.
`ifndef SHA256_STREAM_HASHER_UNIT_DEFINES_SVH
`define SHA256_STREAM_HASHER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SHS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define SHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SHS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SHS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/shs_pkg.sv -----
// Package: SHA-256 constants, the rotate function and controller types.
package shs_pkg;
	typedef enum logic [2:0] {
		ST_IDLE, ST_PAD, ST_ROUND, ST_FOLD, ST_OUT
	} shs_state_t;

	typedef struct packed {
		logic       load_byte;
		logic [7:0] byte_val;
		logic       start_block;
		logic       do_round;
		logic       fold;
		logic       reset_hash;
	} shs_cmd_t;

	typedef struct packed {
		logic [5:0] byte_count;
		logic       round_last;
	} shs_status_t;

	localparam logic [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [31:0] K_ROM [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction
endpackage

// ----- hw/rtl/sha256_stream_hasher_unit.sv -----
// Top level of the byte-serial SHA-256 stream hasher.
//  channel | direction | handshake            | word contents
//  in      | input     | in_valid / in_ready  | msg_byte, byte_present, final_item
//  out     | output    | out_valid / out_ready| digest_word, word_index, last_word
// One byte is taken per handshake; every 64th byte starts a 64-round compression
// (one round per cycle, then a fold), during which in_ready stays low.
// A final word adds one padding byte per cycle, pausing for each compression, through 1 or 2 blocks, then the
// eight digest words are offered one per cycle while out_ready is high.
// Reset restores the initial hash values and clears the length and byte count.
// A stalled output holds the current digest word; no input is taken until
// all eight words leave.
`include "sha256_stream_hasher_unit_defines.svh"
module sha256_stream_hasher_unit import shs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  msg_byte,
	input  logic        byte_present,
	input  logic        final_item,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	shs_cmd_t    cmd;
	shs_status_t status;
	logic [2:0]  idx;

	// Sequence the block: bytes, padding, rounds, fold, output.
	shs_controller u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .msg_byte, .byte_present,
		.final_item, .out_valid, .out_ready, .out_idx(idx), .cmd, .status
	);

	// Hold the block words, working variables and hash state.
	shs_datapath u_dp (
		.clk, .arst_n, .cmd, .status, .out_idx(idx), .hash_out(digest_word)
	);

	assign word_index = idx;
	assign last_word  = (idx == 3'd7);

	// Never take input while digest words are pending.
	`SHS_ASSERT_IMPL(a_no_overlap, clk, arst_n, out_valid, !in_ready)
	// Last digest word returns the unit to accepting input.
	`SHS_ASSERT_NEXT(a_back_idle, clk, arst_n, out_valid && out_ready && last_word, in_ready)
	// Rounds never load bytes or fold at the same time.
	`SHS_ASSERT_IMPL(a_excl, clk, arst_n, cmd.do_round, !cmd.load_byte && !cmd.fold)
endmodule

// ----- hw/rtl/shs_datapath.sv -----
// Datapath: block buffer, schedule, round logic, hash words.
module shs_datapath import shs_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  shs_cmd_t      cmd,
	output shs_status_t   status,
	input  logic [2:0]    out_idx,
	output logic [31:0]   hash_out
);
	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] h_q [8];
	logic [5:0]  cnt_q;
	logic [6:0]  round_q;
	logic [31:0] w_new, t1, t2, s0, s1, ws0, ws1;
	logic [31:0] x2, x15;

	assign status.byte_count = cnt_q;
	assign status.round_last = (round_q == 7'd63);
	assign hash_out = h_q[out_idx];

	always_comb begin
		x2  = w_q[4'(round_q - 7'd2)];
		x15 = w_q[4'(round_q - 7'd15)];
		ws1 = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
		ws0 = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
		if (round_q >= 7'd16) begin
			w_new = w_q[round_q[3:0]] + ws1 + w_q[4'(round_q - 7'd7)] + ws0;
		end else begin
			w_new = w_q[round_q[3:0]];
		end
		s1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
		t1 = v_q[7] + s1 + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ K_ROM[round_q[5:0]] + w_new;
		s0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
		t2 = s0 + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk) begin
		if (cmd.load_byte) begin
			w_q[cnt_q[5:2]] <= {w_q[cnt_q[5:2]][23:0], cmd.byte_val};
		end else if (cmd.do_round) begin
			w_q[round_q[3:0]] <= w_new;
		end
		if (cmd.start_block) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end else if (cmd.do_round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) h_q[i] <= IV[i];
			cnt_q   <= '0;
			round_q <= '0;
		end else begin
			if (cmd.load_byte) cnt_q <= cnt_q + 6'd1;
			if (cmd.start_block) round_q <= '0;
			else if (cmd.do_round) round_q <= round_q + 7'd1;
			if (cmd.reset_hash) begin
				for (int i = 0; i < 8; i++) h_q[i] <= IV[i];
			end else if (cmd.fold) begin
				for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
			end
		end
	end
endmodule

// ----- hw/rtl/shs_controller.sv -----
// Controller: sequences bytes, padding, rounds, fold and digest output.
module shs_controller import shs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [7:0]   msg_byte,
	input  logic         byte_present,
	input  logic         final_item,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [2:0]   out_idx,
	output shs_cmd_t     cmd,
	input  shs_status_t  status
);
	shs_state_t  state_q, state_d;
	logic [63:0] len_q, len_d;
	logic        fin_q, fin_d;
	logic [3:0]  pad_q, pad_d;   // 0: 0x80 pending, 1: zeros, 2..9: length bytes
	logic [2:0]  idx_q, idx_d;
	logic        full;

	assign out_idx = idx_q;
	assign full = (status.byte_count == 6'd63);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q   <= '0;
			fin_q   <= 1'b0;
			pad_q   <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			fin_q   <= fin_d;
			pad_q   <= pad_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		len_d    = len_q;
		fin_d    = fin_q;
		pad_d    = pad_q;
		idx_d    = idx_q;
		in_ready = 1'b0;
		out_valid = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (byte_present) begin
						cmd.load_byte = 1'b1;
						cmd.byte_val  = msg_byte;
						len_d = len_q + 64'd8;
					end
					fin_d = final_item;
					pad_d = '0;
					if (byte_present && full) begin
						cmd.start_block = 1'b1;
						state_d = ST_ROUND;
					end else if (final_item) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				cmd.load_byte = 1'b1;
				if (pad_q == 4'd0) begin
					cmd.byte_val = PAD_BYTE;
					pad_d = (status.byte_count == 6'd55) ? 4'd2 : 4'd1;
				end else if (pad_q == 4'd1) begin
					cmd.byte_val = '0;
					if (status.byte_count == 6'd55) pad_d = 4'd2;
				end else begin
					cmd.byte_val = len_q[8*(4'd9 - pad_q) +: 8];
					pad_d = pad_q + 4'd1;
				end
				if (full) begin
					cmd.start_block = 1'b1;
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				cmd.do_round = 1'b1;
				if (status.round_last) state_d = ST_FOLD;
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				if (!fin_q) state_d = ST_IDLE;
				else if (pad_q == 4'd10) begin
					state_d = ST_OUT;
					idx_d = '0;
				end else state_d = ST_PAD;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					idx_d = idx_q + 3'd1;
					if (idx_q == 3'd7) begin
						cmd.reset_hash = 1'b1;
						len_d = '0;
						fin_d = 1'b0;
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// ----- tb/sha256_stream_hasher_unit_checker.sv -----
// Digest predictor and scoreboard for the SHA-256 stream hasher.
`timescale 1ns / 1ps
module sha256_stream_hasher_unit_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  msg_byte,
	input  logic        byte_present,
	input  logic        final_item,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] digest_word,
	input  logic [2:0]  word_index,
	input  logic        last_word,
	output int          error_count,
	output int          pending_words,
	output int          digests_seen
);
	typedef struct packed {
		logic [31:0] value;
		logic [2:0]  index;
		logic        last;
	} digest_word_t;

	digest_word_t expected_words[$];
	logic [31:0] hash_state[8];
	logic [31:0] block_words[16];
	logic [5:0]  bytes_in_block;
	logic [63:0] bit_length;

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic clear_state();
		hash_state = shs_pkg::IV;
		foreach (block_words[i]) block_words[i] = '0;
		bytes_in_block = '0;
		bit_length = '0;
	endtask

	task automatic compress();
		logic [31:0] v[8];
		logic [31:0] w, t1, t2, s0, s1, x2, x15;
		v = hash_state;
		for (int r = 0; r < 64; r++) begin
			if (r >= 16) begin
				x2  = block_words[(r - 2) & 15];
				x15 = block_words[(r - 15) & 15];
				s1 = ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10);
				s0 = ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3);
				block_words[r & 15] = block_words[r & 15] + s1
					+ block_words[(r - 7) & 15] + s0;
			end
			w = block_words[r & 15];
			s1 = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
			t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + shs_pkg::K_ROM[r] + w;
			s0 = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
			t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			for (int k = 7; k > 0; k--) v[k] = v[k - 1];
			v[4] = v[4] + t1;
			v[0] = t1 + t2;
		end
		foreach (hash_state[k]) hash_state[k] = hash_state[k] + v[k];
	endtask

	// shift a byte into its word; a full block triggers compression
	task automatic absorb(input logic [7:0] b);
		block_words[bytes_in_block[5:2]] = {block_words[bytes_in_block[5:2]][23:0], b};
		bytes_in_block = bytes_in_block + 1'b1;
		if (bytes_in_block == 0) compress();
	endtask

	task automatic take_word(input logic [7:0] b, input logic present, input logic fin);
		logic [63:0] len;
		digest_word_t d;
		if (present) begin
			absorb(b);
			bit_length = bit_length + 64'd8;
		end
		if (fin) begin
			len = bit_length;
			absorb(shs_pkg::PAD_BYTE);
			while (bytes_in_block != shs_pkg::LEN_POS) absorb(8'h00);
			for (int k = 0; k < 8; k++) absorb(len[63 - 8 * k -: 8]);
			for (int k = 0; k < 8; k++) begin
				d.value = hash_state[k];
				d.index = k[2:0];
				d.last  = (k == 7);
				expected_words.push_back(d);
			end
			clear_state();
		end
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t mismatch: %s got %h expected %h", $realtime, what, got, want);
		error_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		digest_word_t d;
		if (!arst_n) begin
			clear_state();
			expected_words.delete();
			error_count = 0;
			digests_seen = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0)
					report("unexpected digest word", digest_word, 32'h0);
				else begin
					d = expected_words.pop_front();
					if (digest_word !== d.value) report("digest_word", digest_word, d.value);
					if (word_index !== d.index) report("word_index", word_index, d.index);
					if (last_word !== d.last) report("last_word", last_word, d.last);
					if (d.last) digests_seen++;
				end
			end
			if (in_valid && in_ready) take_word(msg_byte, byte_present, final_item);
		end
		pending_words = expected_words.size();
	end
endmodule

// ----- tb/sha256_stream_hasher_unit_tb.sv -----
// Stimulus and verdict for the SHA-256 stream hasher.
`timescale 1ns / 1ps
module sha256_stream_hasher_unit_tb;
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  msg_byte = '0;
	logic        byte_present = 1'b0;
	logic        final_item = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	int          error_count, pending_words, digests_seen;
	int          words_sent = 0;
	int          empty_seen = 0;
	bit          stimulus_done = 1'b0;
	bit          hold_sink = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sha256_stream_hasher_unit dut (.*);

	sha256_stream_hasher_unit_checker scoreboard (.*);

	// drive one word; hold valid and payload until the handshake
	task automatic send_word(input logic [7:0] b, input logic present, input logic fin,
			input int gap_max);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		msg_byte     <= b;
		byte_present <= present;
		final_item   <= fin;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		words_sent++;
		if (!present && !fin) empty_seen++;
	endtask

	// a message of n random bytes, final carried by the last byte or by an extra empty word
	task automatic send_message(input int n, input bit final_on_byte, input int gap_max);
		for (int i = 0; i < n; i++)
			send_word(8'($urandom_range(0, 255)), 1'b1,
				final_on_byte && (i == n - 1), gap_max);
		if (!final_on_byte || n == 0)
			send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1, gap_max);
	endtask

	// sink: random stall per word, plus a long hold-off on request
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
			if (hold_sink) begin
				stall = 300;
				hold_sink = 1'b0;
			end
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		int n;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// empty message, a junk empty word, 1- and 3-byte messages, then the padding edge lengths: 55, 56, 63, 64 bytes
		send_word(8'h00, 1'b0, 1'b1, 0);
		send_word(8'hff, 1'b0, 1'b0, 0);
		send_word(8'h61, 1'b1, 1'b1, 0);
		send_word(8'hff, 1'b1, 1'b0, 0);
		send_word(8'h00, 1'b1, 1'b0, 0);
		send_word(8'h80, 1'b1, 1'b1, 0);
		send_message(55, 1'b1, 0);
		send_message(56, 1'b0, 0);
		send_message(63, 1'b1, 0);
		send_message(64, 1'b0, 0);
		// long output hold while the sender keeps going, so input backs up
		hold_sink = 1'b1;
		send_message(3, 1'b1, 0);
		send_message(5, 1'b0, 0);
		send_message(2, 1'b1, 0);
		// random messages: mostly short, some spanning blocks, some junk empties
		while (words_sent < 250) begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 12);
			if (n > 260 - words_sent) n = 260 - words_sent;
			if ($urandom_range(0, 5) == 0)
				send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, 15);
			send_message(n, 1'($urandom_range(0, 1)), ($urandom_range(0, 2) == 0) ? 0 : 15);
		end
		in_valid <= 1'b0;
		stimulus_done = 1'b1;
		while (pending_words != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("covered %0d input words (%0d empty), %0d digests checked",
			words_sent, empty_seen, digests_seen);
		$display("including empty, single-byte and 55/56/63/64-byte padding edges");
		if (error_count == 0)
			$display("sha256_stream_hasher_unit_tb: done, clean");
		else
			$display("sha256_stream_hasher_unit_tb: done, errors");
		$finish;
	end

	initial begin
		#20ms;
		$display("sha256_stream_hasher_unit_tb: done, errors");
		$finish;
	end
endmodule
